// ----- rtl/cwbe_pkg.sv -----
// Shared constants and types for the cost weighted eviction table.
package cwbe_pkg;

	localparam int DEPTH = 256;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;

	typedef struct packed {
		logic [31:0]        id;
		logic signed [31:0] nt;
		logic signed [15:0] cost;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LOOK,
		S_DECIDE,
		S_VISSUE,
		S_VDATA,
		S_VMUL,
		S_VCMP,
		S_EVICT,
		S_DONE
	} state_t;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic REG_SAMPLE_COUNT = 1'b0;
	localparam logic REG_CAPACITY     = 1'b1;

endpackage

// ----- rtl/cwbe_table.sv -----
// Entry store: one write port, one read port, registered read data.
module cwbe_table import cwbe_pkg::*; (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/cost_weighted_belady_eviction.sv -----
// Top level: fully associative object table with sampled cost weighted eviction.
// Sequence: the lookup walks every slot; a miss into a full table adds a victim walk that
// reads and compares each occupied slot examined, passes over empty slots and then closes
// (a never-used entry ends it early), then evicts and inserts, and then loads the
// result. One item at a time.
// Reset clears valid bits, occupancy, request counter and scan pointer; the store is not cleared.
module cost_weighted_belady_eviction import cwbe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               opcode,
	input  logic [31:0]        obj_id,
	input  logic signed [31:0] next_access_time,
	input  logic signed [15:0] cost,
	input  logic               cost_present,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic               evicted_valid,
	output logic [31:0]        evicted_id,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [8:0]         cfg_wdata
);

	state_t state_q, state_d;

	logic [8:0]        sample_q, cap_q;
	logic [DEPTH-1:0]  valid_q;
	logic [CW-1:0]     occ_q;
	logic [31:0]       rc_q;
	logic [AW-1:0]     scan_q;

	logic              op_q, cp_q;
	logic [31:0]       id_q;
	logic signed [31:0] nt_q;
	logic signed [15:0] cost_q;

	logic [CW-1:0]     lk_q;
	logic              pend_s1;
	logic [AW-1:0]     lk_idx_s1;
	logic              hit_q, free_q;
	logic [AW-1:0]     hit_idx_q, free_idx_q;
	logic signed [15:0] hit_cost_q;

	logic [AW-1:0]     pos_q, cur_idx_q;
	logic [CW-1:0]     step_q;
	logic [8:0]        taken_q;
	logic              none_q;
	logic [AW-1:0]     best_idx_q;
	logic [31:0]       best_id_q, cur_id_q;
	logic signed [33:0] best_td_q, cur_td_q;
	logic [14:0]       best_c_q, cur_c_q;
	logic [45:0]       p_new_q, p_best_q;

	logic              res_found_q, res_ev_q;
	logic [31:0]       res_id_q;
	logic              out_valid_q, found_q, ev_valid_q;
	logic [31:0]       ev_id_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	entry_t            mem_wdata, mem_rdata;

	logic [8:0]        n_eff;
	logic [CW-1:0]     cap_eff;
	logic              walk_end, need_evict, do_ins;
	logic [AW-1:0]     pos_nx, ins_idx;
	logic signed [31:0] nt_in;
	logic              take;
	logic [DEPTH-1:0]  valid_ev;

	cwbe_table u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		n_eff = (sample_q == 9'd0) ? 9'd1 : sample_q;
		if (cap_q == 9'd0) begin
			cap_eff = CW'(1);
		end else if (32'(cap_q) > 32'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = CW'(cap_q);
		end
		need_evict = 32'(occ_q) >= 32'(cap_eff);
		walk_end   = (step_q == CW'(DEPTH)) || (taken_q >= n_eff);
		pos_nx     = (32'(pos_q) == DEPTH - 1) ? '0 : pos_q + AW'(1);
		nt_in      = (next_access_time == 32'sh7fffffff) ? -32'sd1 : next_access_time;
		// evicted slot is free too; lowest of the two free candidates wins
		if (!none_q && (!free_q || best_idx_q < free_idx_q)) begin
			ins_idx = best_idx_q;
			do_ins  = 1'b1;
		end else begin
			ins_idx = free_idx_q;
			do_ins  = free_q;
		end
		valid_ev = valid_q;
		if (!none_q) begin
			valid_ev[best_idx_q] = 1'b0;
		end
		if (do_ins) begin
			valid_ev[ins_idx] = 1'b1;
		end
		if (none_q) begin
			take = 1'b1;
		end else if (cur_td_q > 34'sd0) begin
			take = (best_td_q <= 34'sd0) || (p_new_q > p_best_q);
		end else begin
			take = 1'b0;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ins_idx;
		mem_wdata = '{id: id_q, nt: nt_q, cost: cost_q};
		mem_raddr = pos_q;
		if (state_q == S_LOOK) begin
			mem_raddr = lk_q[AW-1:0];
		end
		if (state_q == S_DECIDE && op_q == OP_ACCESS && hit_q) begin
			mem_we    = 1'b1;
			mem_waddr = hit_idx_q;
			mem_wdata = '{id: id_q, nt: nt_q, cost: cp_q ? cost_q : hit_cost_q};
		end else if (state_q == S_EVICT && do_ins) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:   if (in_valid) state_d = S_LOOK;
			S_LOOK:   if (lk_q == CW'(DEPTH)) state_d = S_DECIDE;
			S_DECIDE: begin
				if (op_q == OP_REMOVE || hit_q) begin
					state_d = S_DONE;
				end else if (need_evict) begin
					state_d = S_VISSUE;
				end else begin
					state_d = S_EVICT;
				end
			end
			S_VISSUE: begin
				if (walk_end) begin
					state_d = S_EVICT;
				end else if (valid_q[pos_q]) begin
					state_d = S_VDATA;
				end
			end
			S_VDATA:  state_d = (mem_rdata.nt == -32'sd1) ? S_EVICT : S_VMUL;
			S_VMUL:   state_d = S_VCMP;
			S_VCMP:   state_d = S_VISSUE;
			S_EVICT:  state_d = S_DONE;
			S_DONE:   if (!out_valid_q || !out_stall) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q    <= 9'd128;
			cap_q       <= 9'd256;
			valid_q     <= '0;
			occ_q       <= '0;
			rc_q        <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SAMPLE_COUNT: sample_q <= cfg_wdata;
					REG_CAPACITY:     cap_q    <= cfg_wdata;
					default:          ;
				endcase
			end
			pend_s1 <= (state_q == S_LOOK) && (lk_q != CW'(DEPTH));
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && opcode == OP_ACCESS) begin
						rc_q <= rc_q + 32'd1;
					end
				end
				S_DECIDE: begin
					if (op_q == OP_REMOVE && hit_q) begin
						valid_q[hit_idx_q] <= 1'b0;
						occ_q <= occ_q - CW'(1);
					end
				end
				S_VISSUE: if (walk_end) scan_q <= pos_q;
				S_VDATA:  if (mem_rdata.nt == -32'sd1) scan_q <= pos_q;
				S_EVICT: begin
					valid_q <= valid_ev;
					occ_q   <= occ_q - CW'(!none_q) + CW'(do_ins);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lk_idx_s1 <= lk_q[AW-1:0];
		// lookup compare, one slot per cycle behind the read
		if (pend_s1) begin
			if (valid_q[lk_idx_s1] && mem_rdata.id == id_q && !hit_q) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= lk_idx_s1;
				hit_cost_q <= mem_rdata.cost;
			end
			if (!valid_q[lk_idx_s1] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= lk_idx_s1;
			end
		end
		case (state_q)
			S_IDLE: begin
				op_q        <= opcode;
				id_q        <= obj_id;
				nt_q        <= nt_in;
				cost_q      <= cost;
				cp_q        <= cost_present;
				lk_q        <= '0;
				hit_q       <= 1'b0;
				free_q      <= 1'b0;
				none_q      <= 1'b1;
				res_found_q <= 1'b0;
				res_ev_q    <= 1'b0;
				res_id_q    <= '0;
			end
			S_LOOK: if (lk_q != CW'(DEPTH)) lk_q <= lk_q + CW'(1);
			S_DECIDE: begin
				res_found_q <= hit_q;
				pos_q       <= scan_q;
				step_q      <= '0;
				taken_q     <= '0;
			end
			S_VISSUE: begin
				if (!walk_end) begin
					cur_idx_q <= pos_q;
					pos_q     <= pos_nx;
					step_q    <= step_q + CW'(1);
					if (valid_q[pos_q]) begin
						taken_q <= taken_q + 9'd1;
					end
				end
			end
			S_VDATA: begin
				cur_id_q <= mem_rdata.id;
				cur_td_q <= 34'($signed(mem_rdata.nt)) - $signed({2'b00, rc_q});
				cur_c_q  <= (mem_rdata.cost <= 16'sd0) ? 15'd1 : mem_rdata.cost[14:0];
				if (mem_rdata.nt == -32'sd1) begin
					none_q     <= 1'b0;
					best_idx_q <= cur_idx_q;
					best_id_q  <= mem_rdata.id;
				end
			end
			S_VMUL: begin
				p_new_q  <= cur_td_q[30:0] * best_c_q;
				p_best_q <= best_td_q[30:0] * cur_c_q;
			end
			S_VCMP: begin
				if (take) begin
					none_q     <= 1'b0;
					best_idx_q <= cur_idx_q;
					best_id_q  <= cur_id_q;
					best_td_q  <= cur_td_q;
					best_c_q   <= cur_c_q;
				end
			end
			S_EVICT: begin
				res_ev_q <= !none_q;
				res_id_q <= none_q ? 32'd0 : best_id_q;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					found_q    <= res_found_q;
					ev_valid_q <= res_ev_q;
					ev_id_q    <= res_id_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_id    = ev_id_q;

endmodule

// ----- test/cost_weighted_belady_eviction_tb.sv -----
// Testbench for the cost weighted sampled eviction table: directed table plus random traffic.
module cost_weighted_belady_eviction_tb import cwbe_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = OP_ACCESS;
	logic [31:0] obj_id = '0;
	logic signed [31:0] next_access_time = '0;
	logic signed [15:0] cost = '0;
	logic cost_present = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic evicted_valid;
	logic [31:0] evicted_id;
	logic cfg_we = 1'b0;
	logic cfg_addr = REG_SAMPLE_COUNT;
	logic [8:0] cfg_wdata = '0;

	cost_weighted_belady_eviction dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#200ms;
		$display("cost_weighted_belady_eviction_tb: done, errors");
		$finish;
	end

	typedef struct packed {
		logic fnd;
		logic ev;
		logic [31:0] eid;
	} outcome_t;

	// shadow of the table
	logic tbl_valid [DEPTH];
	logic [31:0] tbl_id [DEPTH];
	logic signed [31:0] tbl_nt [DEPTH];
	logic signed [15:0] tbl_cost [DEPTH];
	int unsigned held, req_clock, scan_pos, samples, cap_limit;

	outcome_t pending[$];
	int errors = 0;
	int hold_off = 0;
	logic free_run = 1'b0;

	function automatic int choose_victim();
		int unsigned n, taken, pos, idx;
		int best;
		longint best_td, best_c, td, c;
		n = (samples == 0) ? 1 : samples;
		taken = 0;
		pos = scan_pos;
		best = -1;
		best_td = 0;
		best_c = 1;
		for (int s = 0; s < DEPTH && taken < n; s++) begin
			idx = pos;
			pos = (pos + 1) % DEPTH;
			if (!tbl_valid[idx]) continue;
			taken++;
			if (tbl_nt[idx] == -1) begin
				best = idx;
				break;
			end
			td = longint'(tbl_nt[idx]) - longint'(req_clock);
			c = (tbl_cost[idx] <= 0) ? 1 : longint'(tbl_cost[idx]);
			if (best < 0) begin
				best = idx; best_td = td; best_c = c;
			end else if (td > 0) begin
				if (best_td <= 0 || td * best_c > best_td * c) begin
					best = idx; best_td = td; best_c = c;
				end
			end
		end
		scan_pos = pos;
		return best;
	endfunction

	function automatic outcome_t apply_request(logic op, logic [31:0] id,
			logic signed [31:0] nt_in, logic signed [15:0] cst, logic cp);
		outcome_t r;
		int hit, v;
		int unsigned cap;
		logic signed [31:0] nt;
		r = '{1'b0, 1'b0, 32'd0};
		nt = (nt_in == -1 || nt_in == 32'sh7fffffff) ? -32'sd1 : nt_in;
		hit = -1;
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i] && tbl_id[i] == id) begin
				hit = i;
				break;
			end
		if (op == OP_REMOVE) begin
			if (hit >= 0) begin
				tbl_valid[hit] = 1'b0;
				if (held > 0) held--;
				r.fnd = 1'b1;
			end
			return r;
		end
		req_clock++;
		if (hit >= 0) begin
			if (cp) tbl_cost[hit] = cst;
			tbl_nt[hit] = nt;
			r.fnd = 1'b1;
			return r;
		end
		cap = (cap_limit == 0) ? 1 : cap_limit;
		if (cap > DEPTH) cap = DEPTH;
		if (held >= cap) begin
			v = choose_victim();
			if (v >= 0) begin
				tbl_valid[v] = 1'b0;
				if (held > 0) held--;
				r.ev = 1'b1;
				r.eid = tbl_id[v];
			end
		end
		for (int i = 0; i < DEPTH; i++)
			if (!tbl_valid[i]) begin
				tbl_valid[i] = 1'b1;
				tbl_id[i] = id;
				tbl_nt[i] = nt;
				tbl_cost[i] = cst;
				held++;
				break;
			end
		return r;
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = pending.pop_front();
				if (found !== e.fnd) begin
					$error("found: expected %0d actual %0d", e.fnd, found);
					errors++;
				end
				if (evicted_valid !== e.ev) begin
					$error("evicted_valid: expected %0d actual %0d", e.ev, evicted_valid);
					errors++;
				end
				if (evicted_id !== e.eid) begin
					$error("evicted_id: expected %0h actual %0h", e.eid, evicted_id);
					errors++;
				end
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= free_run ? 1'b0 : ($urandom_range(99) < 15);
	end

	task automatic set_reg(logic a, logic [8:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (a == REG_SAMPLE_COUNT) samples = v;
		else cap_limit = v;
	endtask

	// wait for the block to drain; results are one per item, so the wait ends once every expected result has come back
	task automatic drain();
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer one transfer and wait for it to be taken
	task automatic send(logic op, logic [31:0] id, logic signed [31:0] nt,
			logic signed [15:0] cst, logic cp, logic gaps);
		while (gaps && !free_run && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		obj_id <= id;
		next_access_time <= nt;
		cost <= cst;
		cost_present <= cp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending.push_back(apply_request(op, id, nt, cst, cp));
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	typedef struct {
		logic op;
		logic [31:0] id;
		logic signed [31:0] nt;
		logic signed [15:0] cst;
		logic cp;
		logic typed;
		outcome_t res;
	} row_t;

	function automatic logic [31:0] rand_id(int pool);
		return (pool == 0) ? $urandom() : 32'(($urandom_range(pool - 1)) * 32'h01010101);
	endfunction

	function automatic logic signed [31:0] rand_nt();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 10) return -32'sd1;
		if (k < 15) return 32'sh7fffffff;
		if (k < 22) return $signed($urandom());
		if (k < 30) return $signed(req_clock - $urandom_range(20));
		return $signed(req_clock + $urandom_range(1, 3000));
	endfunction

	initial begin
		row_t dir [$];
		outcome_t got;
		int pool;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_id[i] = '0;
			tbl_nt[i] = '0;
			tbl_cost[i] = '0;
		end
		held = 0; req_clock = 0; scan_pos = 0; samples = 128; cap_limit = 256;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small table so evictions come early
		set_reg(REG_CAPACITY, 9'd3);
		set_reg(REG_SAMPLE_COUNT, 9'd256);
		dir = '{
			'{OP_REMOVE, 32'hffffffff, 32'sd5, 16'sd1, 1'b0, 1'b1, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h0, 32'sd100, 16'sd10, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h0, 32'sd50, 16'sd5, 1'b1, 1'b1, '{1'b1, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'hffffffff, 32'sh7fffffff, 16'sh7fff, 1'b0, 1'b1,
				'{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h12345678, -32'sd1, -16'sh8000, 1'b1, 1'b1, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h5a5a5a5a, 32'sd40, 16'sd0, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'ha5a5a5a5, 32'sd60, -16'sd3, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_REMOVE, 32'h12345678, 32'sd0, 16'sd0, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h0, 32'sd3, 16'sd1, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h77, 32'sh80000000, 16'sd2, 1'b1, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h78, 32'sd200, 16'sd7, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h79, 32'sd300, 16'sd1, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_ACCESS, 32'h78, 32'sd20, 16'sd9, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_REMOVE, 32'h0, 32'sd0, 16'sd0, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}},
			'{OP_REMOVE, 32'h0, 32'sd0, 16'sd0, 1'b0, 1'b0, '{1'b0, 1'b0, 32'd0}}
		};
		foreach (dir[k]) begin
			send(dir[k].op, dir[k].id, dir[k].nt, dir[k].cst, dir[k].cp, 1'b1);
			if (dir[k].typed) begin
				got = pending[$];
				if (got != dir[k].res) begin
					$error("row %0d: model disagrees with typed result", k);
					errors++;
				end
			end
		end
		idle_input();
		drain();

		// extremes of the registers; zero values saturate in the block
		set_reg(REG_SAMPLE_COUNT, 9'd0);
		set_reg(REG_CAPACITY, 9'd0);
		for (int k = 0; k < 12; k++)
			send($urandom_range(3) == 0, rand_id(6), rand_nt(), 16'($urandom()),
				1'($urandom()), 1'b1);
		idle_input();
		drain();

		// receiver holds off while the sender keeps offering
		hold_off = 600;
		for (int k = 0; k < 6; k++)
			send(OP_ACCESS, rand_id(8), rand_nt(), 16'($urandom()), 1'b1, 1'b0);
		idle_input();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin set_reg(REG_SAMPLE_COUNT, 9'd1); set_reg(REG_CAPACITY, 9'd1); end
				1: begin set_reg(REG_SAMPLE_COUNT, 9'd4); set_reg(REG_CAPACITY, 9'd8); end
				2: begin set_reg(REG_SAMPLE_COUNT, 9'd511); set_reg(REG_CAPACITY, 9'd16); end
				3: begin set_reg(REG_SAMPLE_COUNT, 9'd128); set_reg(REG_CAPACITY, 9'd256); end
				4: begin set_reg(REG_SAMPLE_COUNT, 9'd256); set_reg(REG_CAPACITY, 9'd511); end
				default: begin
					// capacity lowered below occupancy
					set_reg(REG_SAMPLE_COUNT, 9'd7); set_reg(REG_CAPACITY, 9'd5);
				end
			endcase
			pool = (ph == 3 || ph == 4) ? 300 : 24;
			free_run = (ph == 2);
			for (int k = 0; k < 240; k++)
				send(($urandom_range(99) < 12) ? OP_REMOVE : OP_ACCESS,
					($urandom_range(99) < 5) ? rand_id(0) : rand_id(pool),
					rand_nt(), 16'($urandom()), 1'($urandom()), 1'b1);
			free_run = 1'b0;
			idle_input();
			// sender pauses until everything has come back
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("cost_weighted_belady_eviction_tb: done, clean");
		else
			$display("cost_weighted_belady_eviction_tb: done, errors");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/cwbe_pkg.sv
rtl/cwbe_table.sv
rtl/cost_weighted_belady_eviction.sv
test/cost_weighted_belady_eviction_tb.sv
